### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, request and status codes of the positional list editor.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_MOVE    = 3'd2;
    localparam logic [2:0] REQ_REVERSE = 3'd3;
    localparam logic [2:0] REQ_ROTL    = 3'd4;
    localparam logic [2:0] REQ_ROTR    = 3'd5;
    localparam logic [2:0] REQ_READ    = 3'd6;
    localparam logic [2:0] REQ_UNUSED  = 3'd7;  // no operation, plain ok status

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Per-cell operation for one cycle
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,  // keep value
        OP_LEFT  = 3'd1,  // take right neighbour
        OP_RIGHT = 3'd2,  // take left neighbour
        OP_LOAD  = 3'd3,  // take the broadcast value
        OP_SWAP  = 3'd4   // take the mirror partner
    } t_cell_op;

endpackage

### rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One storage cell of the chain: holds one element, shifts to neighbours.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_cell_op               i_op,
    input  logic [VALUE_WIDTH-1:0] i_from_left,
    input  logic [VALUE_WIDTH-1:0] i_from_right,
    input  logic [VALUE_WIDTH-1:0] i_load,
    input  logic [VALUE_WIDTH-1:0] i_mirror,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LEFT:  r_value <= i_from_right;
            OP_RIGHT: r_value <= i_from_left;
            OP_LOAD:  r_value <= i_load;
            OP_SWAP:  r_value <= i_mirror;
            default:  r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

### rtl/positional_list_editor_top.sv
// ----------------------------------------------------------------------------
// positional_list_editor_top
// Ordered list of signed values in a chain of cells, edited one request at
// a time: insert, remove, move, reverse, rotate and read out.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_axis  | in  | tdata: req_type[2:0] item_value[34:3] position[40:35]
//          |     |        target_position[45:41] amount[61:46]
//  m_axis  | out | tdata: out_value[31:0] out_index[36:32] status[38:37];
//          |     | tlast: last_of_run
//
// Sequencing: a request is accepted only when the block is idle. Insert,
// remove and move shift the chain one place a cycle over the affected span;
// insert and move then load the end cell. Reverse swaps the cells of the
// list in the accepting cycle. A rotate first takes amount mod length, one
// amount bit a cycle, then rotates left one place a cycle (the remainder, or
// length minus it for a right rotate). A read gives one beat a cycle, one
// per element, while m_axis is not stalled. Every request then waits until
// its last beat has left. Reset (synchronous, active low) clears the length
// and control only; cells are not cleared.
// A stalled m_axis beat holds in its output register until taken.
// ----------------------------------------------------------------------------
module positional_list_editor_top
    import ple_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type, item_value, position, target_position, amount (from bit 0)
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value, out_index, status (from bit 0)
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SHIFT = 7'b0000010,  // shift a span left or right
        S_MOD   = 7'b0000100,  // amount mod length, one bit a cycle
        S_ROT   = 7'b0001000,  // rotate left one place a cycle
        S_READ  = 7'b0010000,  // stream elements out
        S_STAT  = 7'b0100000,  // give one status beat
        S_WAIT  = 7'b1000000   // drain the last beat
    } t_state;

    t_state r_state;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_lo, r_hi;     // shift span, inclusive
    logic          r_dir_left;
    logic          r_final_load;
    logic [LW-1:0] r_load_idx;
    logic [VALUE_WIDTH-1:0] r_held;
    logic [16:0]   r_rem;
    logic [15:0]   r_amt;
    logic [4:0]    r_bit;
    logic          r_rot_right;
    logic [LW-1:0] r_cnt;
    logic [1:0]    r_status;
    logic          r_ov;
    logic [VALUE_WIDTH-1:0] r_ov_val;
    logic [4:0]    r_ov_idx;
    logic          r_ov_last;
    logic [1:0]    r_ov_st;

    logic [2:0]  in_req;
    logic [31:0] in_val;
    logic [5:0]  in_pos;
    logic [4:0]  in_tgt;
    logic [15:0] in_amt;
    assign in_req = s_axis_tdata[2:0];
    assign in_val = s_axis_tdata[34:3];
    assign in_pos = s_axis_tdata[40:35];
    assign in_tgt = s_axis_tdata[45:41];
    assign in_amt = s_axis_tdata[61:46];

    logic [VALUE_WIDTH-1:0] cell_q  [DEPTH];
    t_cell_op               cell_op [DEPTH];
    logic [VALUE_WIDTH-1:0] load_val;

    logic out_free;
    logic ov_load;
    assign out_free = !r_ov || m_axis_tready;
    assign ov_load  = ((r_state == S_READ) || (r_state == S_STAT)) && out_free;
    assign s_axis_tready = (r_state == S_IDLE);

    // The whole row: each cell sees its neighbours and its mirror partner
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left, w_right, w_mirror;
        logic [LW:0] w_mi;
        assign w_left  = (g > 0) ? cell_q[(g > 0) ? g - 1 : 0] : cell_q[0];
        assign w_right = (g < DEPTH - 1) ? cell_q[(g < DEPTH - 1) ? g + 1 : g] : cell_q[g];
        // mirror index length-1-g, used only when g < length
        assign w_mi = {1'b0, r_len} - (LW + 1)'(g) - (LW + 1)'(1);
        assign w_mirror = cell_q[w_mi[IW-1:0]];
        ple_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op[g]),
            .i_from_left (w_left),
            .i_from_right(w_right),
            .i_load      (load_val),
            .i_mirror    (w_mirror),
            .o_value     (cell_q[g])
        );
    end

    // Reverse one-shot flag and rotate-step flag drive the cell controls
    logic do_rev;
    logic do_rot;
    logic [VALUE_WIDTH-1:0] ins_val;
    // cut or sign-extend the request value to the stored width
    assign ins_val = VALUE_WIDTH'(signed'(in_val));

    always_comb begin
        do_rev = (r_state == S_IDLE) && s_axis_tvalid && (in_req == REQ_REVERSE);
        do_rot = (r_state == S_ROT) && (r_cnt != '0);
        load_val = r_held;
        for (int k = 0; k < DEPTH; k++) begin
            cell_op[k] = OP_HOLD;
            if (do_rev && (LW'(k) < r_len)) begin
                cell_op[k] = OP_SWAP;
            end else if (do_rot && (LW'(k) < r_len)) begin
                cell_op[k] = (LW'(k) == r_len - LW'(1)) ? OP_LOAD : OP_LEFT;
            end else if (r_state == S_SHIFT) begin
                if (r_lo == r_hi) begin
                    if (r_final_load && LW'(k) == r_load_idx) cell_op[k] = OP_LOAD;
                end else if (r_dir_left) begin
                    if (LW'(k) == r_lo) cell_op[k] = OP_LEFT;
                end else begin
                    if (LW'(k) == r_hi) cell_op[k] = OP_RIGHT;
                end
            end
        end
        if (do_rot) load_val = cell_q[0];
    end

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    assign rem_sh  = {r_rem[15:0], r_amt[r_bit[3:0]]};
    assign rem_sub = rem_sh - 17'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            // Load a new beat when the register is free, else drop a taken one
            if (ov_load) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_status <= ST_OK;
                        r_state  <= S_STAT;
                        case (in_req)
                            REQ_INSERT: begin
                                if (r_len >= LW'(DEPTH)) r_status <= ST_FULL;
                                else if ({1'b0, in_pos} > 7'(r_len)) r_status <= ST_RANGE;
                                else begin
                                    r_state      <= S_SHIFT;
                                    r_dir_left   <= 1'b0;
                                    r_lo         <= LW'(in_pos);
                                    r_hi         <= r_len;
                                    r_final_load <= 1'b1;
                                    r_load_idx   <= LW'(in_pos);
                                    r_held       <= ins_val;
                                    r_len        <= r_len + LW'(1);
                                end
                            end
                            REQ_REMOVE: begin
                                if (r_len == '0) r_status <= ST_EMPTY;
                                else if ({1'b0, in_pos} >= 7'(r_len)) r_status <= ST_RANGE;
                                else begin
                                    r_state      <= S_SHIFT;
                                    r_dir_left   <= 1'b1;
                                    r_lo         <= LW'(in_pos);
                                    r_hi         <= r_len - LW'(1);
                                    r_final_load <= 1'b0;
                                    r_len        <= r_len - LW'(1);
                                end
                            end
                            REQ_MOVE: begin
                                if (r_len == '0) r_status <= ST_EMPTY;
                                else if ({1'b0, in_pos} >= 7'(r_len) ||
                                         {2'b0, in_tgt} >= 7'(r_len))
                                    r_status <= ST_RANGE;
                                else begin
                                    r_state      <= S_SHIFT;
                                    r_final_load <= 1'b1;
                                    r_load_idx   <= LW'(in_tgt);
                                    r_held       <= cell_q[in_pos[IW-1:0]];
                                    r_dir_left   <= (in_pos < {1'b0, in_tgt});
                                    if (in_pos < {1'b0, in_tgt}) begin
                                        r_lo <= LW'(in_pos);
                                        r_hi <= LW'(in_tgt);
                                    end else begin
                                        r_lo <= LW'(in_tgt);
                                        r_hi <= LW'(in_pos);
                                    end
                                end
                            end
                            REQ_REVERSE: ;
                            REQ_ROTL, REQ_ROTR: begin
                                if (r_len == '0) r_status <= ST_EMPTY;
                                else begin
                                    r_state     <= S_MOD;
                                    r_amt       <= in_amt;
                                    r_bit       <= 5'd15;
                                    r_rem       <= '0;
                                    r_rot_right <= (in_req == REQ_ROTR);
                                end
                            end
                            REQ_READ: begin
                                if (r_len == '0) r_status <= ST_EMPTY;
                                else begin
                                    r_state <= S_READ;
                                    r_cnt   <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT: begin
                    // Advance the span one place; a length-one span ends it, with the final load if any
                    if (r_lo == r_hi) r_state <= S_STAT;
                    else if (r_dir_left) r_lo <= r_lo + LW'(1);
                    else r_hi <= r_hi - LW'(1);
                    if (r_lo != r_hi && !r_dir_left && r_lo + LW'(1) == r_hi && !r_final_load)
                        r_state <= S_STAT;
                end
                S_MOD: begin
                    r_rem <= (rem_sh >= 17'(r_len)) ? rem_sub : rem_sh;
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_state <= S_ROT;
                        if (!r_rot_right || ((rem_sh >= 17'(r_len)) ? rem_sub : rem_sh) == '0)
                            r_cnt <= LW'((rem_sh >= 17'(r_len)) ? rem_sub : rem_sh);
                        else
                            r_cnt <= r_len - LW'((rem_sh >= 17'(r_len)) ? rem_sub : rem_sh);
                    end
                end
                S_ROT: begin
                    if (r_cnt == '0) r_state <= S_STAT;
                    else r_cnt <= r_cnt - LW'(1);
                end
                S_READ: begin
                    if (out_free) begin
                        r_ov_val  <= cell_q[r_cnt[IW-1:0]];
                        r_ov_idx  <= 5'(r_cnt);
                        r_ov_st   <= ST_OK;
                        r_ov_last <= (r_cnt + LW'(1) == r_len);
                        r_cnt     <= r_cnt + LW'(1);
                        if (r_cnt + LW'(1) == r_len) r_state <= S_WAIT;
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_ov_val  <= '0;
                        r_ov_idx  <= '0;
                        r_ov_st   <= r_status;
                        r_ov_last <= 1'b1;
                        r_state   <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // Hold new requests until the last beat has left
                    if (!r_ov || m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [31:0] ov_ext;
    assign ov_ext = 32'(signed'(r_ov_val));

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_ov_st, r_ov_idx, ov_ext};
    assign m_axis_tlast  = r_ov_last;

endmodule
